>>> design/nrpl_pkg.sv
// Package for the nearest-red pixel locator: constants, register indexes,
// and the dimension clamp used by the front end.
package nrpl_pkg;

  localparam int unsigned DEF_MAX_DIM    = 4096;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned DIST_W         = 18;
  localparam int unsigned POS_OUT_W      = 12;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned FRAME_W_RST    = 640;
  localparam int unsigned FRAME_H_RST    = 480;
  localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // last index of a dimension: zero counts as one, above max_dim counts as max_dim
  function automatic int unsigned clamp_last(logic [CFG_DATA_W-1:0] v,
                                             int unsigned max_dim);
    int unsigned vv;
    vv = 32'(v);
    if (vv == 0) begin
      return 0;
    end else if (vv > max_dim) begin
      return max_dim - 1;
    end else begin
      return vv - 1;
    end
  endfunction

endpackage

>>> design/nearest_red_pixel_locator.sv
// Top level of the nearest-red pixel locator: front end, queue, back end.
// Depends on nrpl_pkg, nrpl_front, nrpl_fifo and nrpl_back.
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | in_blue, in_green, in_red (8 b each)
//  out     | out_valid / out_ready  | out_best_row, out_best_column (12 b),
//          |                        | out_best_distance (18 b)
//  cfg     | cfg_valid / cfg_ready  | cfg_index (0 width, 1 height), cfg_data (13 b)
//
// One pixel per cycle while the queue is not full; the distance is formed in the accept cycle.
// The frame result is registered in the back end once its last pixel leaves the queue.
// Reset sets 640 x 480 and clears the counters and search state; cfg_ready is always high.
// A stalled result holds the output register; pixels keep flowing until the next
// end-of-frame pixel reaches the head of the 4-entry queue, and in_ready drops
// once the queue behind it fills.
module nearest_red_pixel_locator import nrpl_pkg::*; #(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_blue,
  input  logic [PIX_W-1:0]      in_green,
  input  logic [PIX_W-1:0]      in_red,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_OUT_W-1:0]  out_best_row,
  output logic [POS_OUT_W-1:0]  out_best_column,
  output logic [DIST_W-1:0]     out_best_distance,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned ENT_W = 1 + 2 * CW + DIST_W;

  logic              push, pop, fifo_full, fifo_not_empty;
  logic [DIST_W-1:0] push_dist, ent_dist;
  logic [CW-1:0]     push_row, push_col, ent_row, ent_col;
  logic              push_last, ent_last;
  logic [ENT_W-1:0]  push_data, pop_data;

  assign cfg_ready = 1'b1;

  nrpl_front #(.MAX_DIM(MAX_DIM), .CW(CW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_dist (push_dist),
    .push_row  (push_row),
    .push_col  (push_col),
    .push_last (push_last)
  );

  assign push_data = {push_last, push_row, push_col, push_dist};

  nrpl_fifo #(.WIDTH(ENT_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .not_empty (fifo_not_empty)
  );

  assign {ent_last, ent_row, ent_col, ent_dist} = pop_data;

  nrpl_back #(.MAX_DIM(MAX_DIM), .CW(CW)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ent_valid         (fifo_not_empty),
    .ent_dist          (ent_dist),
    .ent_row           (ent_row),
    .ent_col           (ent_col),
    .ent_last          (ent_last),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_best_row      (out_best_row),
    .out_best_column   (out_best_column),
    .out_best_distance (out_best_distance)
  );

endmodule

>>> design/nrpl_fifo.sv
// Small register FIFO that decouples the pixel front end from the search back end.
// Depends on nrpl_pkg for nothing but is kept with the block's files.
module nrpl_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/nrpl_front.sv
// Front end: accepts pixels, computes the squared distance to pure red,
// tracks raster position and frame end, holds the dimension registers. Uses nrpl_pkg.
module nrpl_front import nrpl_pkg::*; #(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM,
  parameter int unsigned CW      = $clog2(MAX_DIM)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_blue,
  input  logic [PIX_W-1:0]      in_green,
  input  logic [PIX_W-1:0]      in_red,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fifo_full,
  output logic                  push,
  output logic [DIST_W-1:0]     push_dist,
  output logic [CW-1:0]         push_row,
  output logic [CW-1:0]         push_col,
  output logic                  push_last
);

  localparam logic [CW-1:0] W_LAST_RST = CW'(clamp_last(CFG_DATA_W'(FRAME_W_RST), MAX_DIM));
  localparam logic [CW-1:0] H_LAST_RST = CW'(clamp_last(CFG_DATA_W'(FRAME_H_RST), MAX_DIM));

  logic [CW-1:0]    w_last_r, w_last_nxt;
  logic [CW-1:0]    h_last_r, h_last_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    row_r, row_nxt;
  logic [PIX_W-1:0] dr;
  logic [15:0]      sq_r, sq_g, sq_b;
  logic             col_wrap, row_wrap;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;

  assign dr   = ~in_red;
  assign sq_r = 16'(dr) * 16'(dr);
  assign sq_g = 16'(in_green) * 16'(in_green);
  assign sq_b = 16'(in_blue) * 16'(in_blue);
  assign push_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  assign col_wrap  = (col_r >= w_last_r);
  assign row_wrap  = (row_r >= h_last_r);
  assign push_row  = row_r;
  assign push_col  = col_r;
  assign push_last = col_wrap && row_wrap;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (push) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_last_nxt = CW'(clamp_last(cfg_data, MAX_DIM));
        REG_FRAME_HEIGHT: h_last_nxt = CW'(clamp_last(cfg_data, MAX_DIM));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= W_LAST_RST;
      h_last_r <= H_LAST_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

>>> design/nrpl_back.sv
// Back end: running minimum search over queued pixels and the result register.
// Uses nrpl_pkg; fed from nrpl_fifo.
module nrpl_back import nrpl_pkg::*; #(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM,
  parameter int unsigned CW      = $clog2(MAX_DIM)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ent_valid,
  input  logic [DIST_W-1:0]    ent_dist,
  input  logic [CW-1:0]        ent_row,
  input  logic [CW-1:0]        ent_col,
  input  logic                 ent_last,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_OUT_W-1:0] out_best_row,
  output logic [POS_OUT_W-1:0] out_best_column,
  output logic [DIST_W-1:0]    out_best_distance
);

  logic [DIST_W-1:0]    min_dist_r, min_dist_nxt;
  logic [CW-1:0]        min_row_r, min_row_nxt;
  logic [CW-1:0]        min_col_r, min_col_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [POS_OUT_W-1:0] out_row_r, out_row_nxt;
  logic [POS_OUT_W-1:0] out_col_r, out_col_nxt;
  logic [DIST_W-1:0]    out_dist_r, out_dist_nxt;
  logic                 better;
  logic [DIST_W-1:0]    cand_dist;
  logic [CW-1:0]        cand_row, cand_col;

  assign pop       = ent_valid && (!ent_last || !out_valid_r || out_ready);
  assign better    = ent_dist < min_dist_r;
  assign cand_dist = better ? ent_dist : min_dist_r;
  assign cand_row  = better ? ent_row : min_row_r;
  assign cand_col  = better ? ent_col : min_col_r;

  always_comb begin
    min_dist_nxt  = min_dist_r;
    min_row_nxt   = min_row_r;
    min_col_nxt   = min_col_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_dist_nxt  = out_dist_r;
    if (pop) begin
      if (ent_last) begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = POS_OUT_W'(cand_row);
        out_col_nxt   = POS_OUT_W'(cand_col);
        out_dist_nxt  = cand_dist;
        min_dist_nxt  = DIST_ALL_ONES;
        min_row_nxt   = '0;
        min_col_nxt   = '0;
      end else begin
        min_dist_nxt = cand_dist;
        min_row_nxt  = cand_row;
        min_col_nxt  = cand_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r  <= DIST_ALL_ONES;
      min_row_r   <= '0;
      min_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      min_dist_r  <= min_dist_nxt;
      min_row_r   <= min_row_nxt;
      min_col_r   <= min_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_best_row      = out_row_r;
  assign out_best_column   = out_col_r;
  assign out_best_distance = out_dist_r;

endmodule

>>> design/nrpl_checker.sv
// Port-level checks for the nearest-red pixel locator, bound to the top level.
// Depends on nrpl_pkg and nearest_red_pixel_locator.
module nrpl_checker import nrpl_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [POS_OUT_W-1:0] out_best_row,
  input logic [POS_OUT_W-1:0] out_best_column,
  input logic [DIST_W-1:0]    out_best_distance
);

  localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_best_row) && $stable(out_best_column)
                                && $stable(out_best_distance))
    else $error("result changed while stalled");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_distance <= DIST_MAX)
    else $error("result distance out of range");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind nearest_red_pixel_locator nrpl_checker u_nrpl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_best_row      (out_best_row),
  .out_best_column   (out_best_column),
  .out_best_distance (out_best_distance)
);
